[rtl/qenc_pkg.sv]
// Shared types, constants and helper functions of the quadrature encoder block.
package qenc_pkg;

    localparam int ENCODER_COUNT = 32;
    localparam int HISTORY_DEPTH = 4;
    localparam int ENC_AW = $clog2(ENCODER_COUNT);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
    localparam int APB_AW = 4;

    localparam logic [6:0] VAL_MAX = 7'd127;
    localparam logic [6:0] VAL_MID = 7'd64;
    localparam logic [6:0] VAL_MIN = 7'd0;
    localparam logic [1:0] PHASE_ALL_ONES = 2'h3;
    localparam logic [1:0] PHASE_ZERO = 2'h0;
    localparam logic [1:0] GRAY_FWD = 2'd1;
    localparam logic [1:0] GRAY_BWD = 2'd3;
    localparam logic KIND_ENCODER = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    typedef enum logic [1:0] {
        REG_DETENT_ONLY       = 2'd0,
        REG_BUTTON_MULTIPLIES = 2'd1,
        REG_ABSOLUTE_MODE     = 2'd2,
        REG_STEP_MULTIPLIER   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [4:0] encoder_index;
        logic [1:0] quad_phase;
        logic       button_raw;
    } in_item_t;

    typedef struct packed {
        logic       event_kind;
        logic [4:0] event_encoder;
        logic [6:0] event_value;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       detent_only;
        logic       button_multiplies;
        logic       absolute_mode;
        logic [6:0] step_multiplier;
    } cfg_t;

    typedef struct packed {
        logic [HISTORY_DEPTH-1:0][1:0] phist;
        logic [HISTORY_DEPTH-1:0]      bhist;
        logic [1:0]                    acc_phase;
        logic                          acc_button;
        logic [6:0]                    abs_value;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    localparam ent_t ENT_RESET = '{
        phist:      {HISTORY_DEPTH{PHASE_ALL_ONES}},
        bhist:      {HISTORY_DEPTH{1'b1}},
        acc_phase:  PHASE_ALL_ONES,
        acc_button: 1'b1,
        abs_value:  VAL_MIN
    };

    typedef struct packed {
        logic      any;
        logic      two;
        out_item_t r0;
        out_item_t r1;
    } res_t;

    function automatic logic [1:0] gray_pos(input logic [1:0] p);
        return {p[1], p[1] ^ p[0]};
    endfunction

    function automatic logic [1:0] gray_dist(input logic [1:0] from, input logic [1:0] to);
        return gray_pos(to) - gray_pos(from);
    endfunction

endpackage

[rtl/qenc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module qenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/qenc_update.sv]
// Per-encoder state update: debounce, Gray decode, step scaling and event forming.
module qenc_update (
    input  qenc_pkg::ent_t     cur,
    input  qenc_pkg::in_item_t item,
    input  qenc_pkg::cfg_t     cfg,
    output qenc_pkg::ent_t     nxt,
    output qenc_pkg::res_t     res
);
    import qenc_pkg::*;

    logic       psame;
    logic       bsame;
    logic [1:0] ring_delta;
    logic       has_step;
    logic       fwd;
    logic [6:0] mag;
    logic [7:0] up_sum;
    logic [6:0] step_val;
    logic       enc_ev;
    logic       btn_ev;
    out_item_t  enc_item;
    out_item_t  btn_item;

    always_comb
    begin
        nxt = cur;
        nxt.phist[0] = item.quad_phase;
        nxt.bhist[0] = item.button_raw;
        psame = 1'b1;
        bsame = 1'b1;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            nxt.phist[i] = cur.phist[i-1];
            nxt.bhist[i] = cur.bhist[i-1];
            if (cur.phist[i-1] != item.quad_phase)
            begin
                psame = 1'b0;
            end
            if (cur.bhist[i-1] != item.button_raw)
            begin
                bsame = 1'b0;
            end
        end

        ring_delta = gray_dist(cur.acc_phase, item.quad_phase);
        fwd = (ring_delta == GRAY_FWD);
        has_step = (ring_delta == GRAY_FWD) || (ring_delta == GRAY_BWD);
        mag = (cfg.button_multiplies && !cur.acc_button) ? cfg.step_multiplier : 7'd1;

        if (cfg.absolute_mode)
        begin
            up_sum = {1'b0, cur.abs_value} + {1'b0, mag};
            if (fwd)
            begin
                step_val = up_sum[7] ? VAL_MAX : up_sum[6:0];
            end
            else
            begin
                step_val = (mag > cur.abs_value) ? VAL_MIN : cur.abs_value - mag;
            end
        end
        else
        begin
            up_sum = {1'b0, VAL_MID} + {1'b0, mag};
            if (fwd)
            begin
                step_val = up_sum[7] ? VAL_MAX : up_sum[6:0];
            end
            else
            begin
                step_val = (mag > VAL_MID) ? VAL_MIN : VAL_MID - mag;
            end
        end

        enc_ev = 1'b0;
        if (psame && (item.quad_phase != cur.acc_phase))
        begin
            nxt.acc_phase = item.quad_phase;
            if ((!cfg.detent_only || item.quad_phase == PHASE_ZERO
                 || item.quad_phase == PHASE_ALL_ONES) && has_step)
            begin
                if (cfg.absolute_mode)
                begin
                    if (step_val != cur.abs_value)
                    begin
                        enc_ev = 1'b1;
                        nxt.abs_value = step_val;
                    end
                end
                else
                begin
                    enc_ev = 1'b1;
                end
            end
        end

        btn_ev = 1'b0;
        if (bsame && (item.button_raw != cur.acc_button))
        begin
            nxt.acc_button = item.button_raw;
            btn_ev = !cfg.button_multiplies;
        end

        enc_item.event_kind = KIND_ENCODER;
        enc_item.event_encoder = item.encoder_index;
        enc_item.event_value = step_val;
        enc_item.last_of_run = !btn_ev;

        btn_item.event_kind = KIND_BUTTON;
        btn_item.event_encoder = item.encoder_index;
        btn_item.event_value = item.button_raw ? VAL_MIN : VAL_MAX;
        btn_item.last_of_run = 1'b1;

        res.any = enc_ev || btn_ev;
        res.two = enc_ev && btn_ev;
        res.r0 = enc_ev ? enc_item : btn_item;
        res.r1 = btn_item;
    end

endmodule

[rtl/qenc_out_fifo.sv]
// Output queue of result pairs, drained one item at a time.
module qenc_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  qenc_pkg::res_t                push_data,
    output logic                          valid,
    input  logic                          ready,
    output qenc_pkg::out_item_t           item,
    output logic [qenc_pkg::FIFO_CW-1:0]  count
);
    import qenc_pkg::*;

    res_t               store [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               half_reg;
    logic               half_next;
    logic               pop;
    logic               take;
    res_t               head;

    assign head = store[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign item = half_reg ? head.r1 : head.r0;
    assign count = count_reg;
    assign take = valid && ready;
    assign pop = take && (half_reg || !head.two);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        half_next = half_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            half_next = !pop;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
            half_reg <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < FIFO_CW'(FIFO_DEPTH)) || pop)
        else $error("Output queue written while full.");

    a_pair_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (take && head.two && !half_reg) |=> (valid && half_reg && item.event_kind == KIND_BUTTON))
        else $error("Second item of a pair was lost.");

endmodule

[rtl/quadrature_encoder_to_control.sv]
// Top level of the quadrature encoder decoder with debounce and control event output.
//
// The block accepts one encoder sample item per clock cycle as long as the four-entry output
// queue has room, and each item yields zero, one or two event items. An accepted item reads its
// encoder's state entry from a synchronous RAM in the cycle it is accepted, is evaluated and
// written back at the end of the next cycle, and its events enter the output queue at that edge,
// from which the first event is offered. Back-to-back items for the same encoder use a forwarding
// path around the RAM. Sustained rate is one item per cycle when each item yields at most one
// event and the consumer is always ready; an item with two events is drained from the output
// queue as two separate items. No clearing pass is needed after reset: per-encoder valid flags
// make unwritten entries read as their reset state.
module quadrature_encoder_to_control (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enc_valid,
    output logic                            enc_ready,
    input  qenc_pkg::in_item_t              enc_item,
    output logic                            evt_valid,
    input  logic                            evt_ready,
    output qenc_pkg::out_item_t             evt_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qenc_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import qenc_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    reg_idx_t           reg_idx;
    logic               cfg_wr;

    logic               accept;
    logic [ENC_AW-1:0]  raddr;
    logic               in_range;
    logic [ENC_AW-1:0]  s1_addr;
    logic [ENT_W-1:0]   ram_rdata;

    logic               s1_valid_reg;
    in_item_t           s1_item_reg;
    logic               s1_vld_reg;
    logic               s1_fwd_reg;
    ent_t               s1_fwd_data_reg;
    logic [ENCODER_COUNT-1:0] vld_reg;
    logic [ENCODER_COUNT-1:0] vld_next;

    ent_t               cur;
    ent_t               nxt;
    res_t               res;
    logic [FIFO_CW-1:0] fifo_count;

    assign pready = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata = '0;
        unique case (reg_idx)
            REG_DETENT_ONLY:
            begin
                prdata[0] = cfg_reg.detent_only;
                if (cfg_wr)
                begin
                    cfg_next.detent_only = pwdata[0];
                end
            end
            REG_BUTTON_MULTIPLIES:
            begin
                prdata[0] = cfg_reg.button_multiplies;
                if (cfg_wr)
                begin
                    cfg_next.button_multiplies = pwdata[0];
                end
            end
            REG_ABSOLUTE_MODE:
            begin
                prdata[0] = cfg_reg.absolute_mode;
                if (cfg_wr)
                begin
                    cfg_next.absolute_mode = pwdata[0];
                end
            end
            REG_STEP_MULTIPLIER:
            begin
                prdata[6:0] = cfg_reg.step_multiplier;
                if (cfg_wr)
                begin
                    cfg_next.step_multiplier = pwdata[6:0];
                end
            end
        endcase
    end

    assign enc_ready = (32'(fifo_count) + 32'(s1_valid_reg)) < FIFO_DEPTH;
    assign accept = enc_valid && enc_ready;
    assign raddr = ENC_AW'(enc_item.encoder_index);
    assign in_range = 32'(enc_item.encoder_index) < ENCODER_COUNT;
    assign s1_addr = ENC_AW'(s1_item_reg.encoder_index);

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            cur = s1_fwd_data_reg;
        end
        else if (s1_vld_reg)
        begin
            cur = ent_t'(ram_rdata);
        end
        else
        begin
            cur = ENT_RESET;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (s1_valid_reg)
        begin
            vld_next[s1_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{detent_only: 1'b1, button_multiplies: 1'b1,
                         absolute_mode: 1'b0, step_multiplier: 7'd8};
            s1_valid_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s1_fwd_reg <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            s1_valid_reg <= accept && in_range;
            s1_vld_reg <= vld_reg[raddr];
            s1_fwd_reg <= s1_valid_reg && (s1_addr == raddr);
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= enc_item;
            s1_fwd_data_reg <= nxt;
        end
    end

    qenc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENCODER_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr),
        .wdata (ENT_W'(nxt)),
        .re    (accept),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    qenc_update u_update (
        .cur  (cur),
        .item (s1_item_reg),
        .cfg  (cfg_reg),
        .nxt  (nxt),
        .res  (res)
    );

    qenc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg && res.any),
        .push_data (res),
        .valid     (evt_valid),
        .ready     (evt_ready),
        .item      (evt_item),
        .count     (fifo_count)
    );

    a_forward_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && s1_addr == raddr) |=> s1_fwd_reg)
        else $error("Back-to-back item for one encoder missed the forwarding path.");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res.two) |-> (res.r0.event_kind == KIND_ENCODER
            && res.r1.event_kind == KIND_BUTTON && !res.r0.last_of_run))
        else $error("Event pair formed in the wrong order.");

    a_multiplier_mode_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res.any && cfg_reg.button_multiplies) |->
            (res.r0.event_kind == KIND_ENCODER && !res.two))
        else $error("Button event produced while the button scales steps.");

endmodule

[sim/quadrature_encoder_to_control_tb.sv]
// Self-checking testbench for the quadrature encoder decoder with debounce.
module quadrature_encoder_to_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qenc_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [3:0][1:0] GRAY_RING = {2'b10, 2'b11, 2'b01, 2'b00};

    logic                clk;
    logic                rst_n;
    logic                enc_valid;
    logic                enc_ready;
    in_item_t            enc_item;
    logic                evt_valid;
    logic                evt_ready;
    out_item_t           evt_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    cfg_t       model_cfg;
    logic [1:0] phase_log [ENCODER_COUNT][HISTORY_DEPTH];
    logic       button_log [ENCODER_COUNT][HISTORY_DEPTH];
    logic [1:0] settled_phase [ENCODER_COUNT];
    logic       settled_button [ENCODER_COUNT];
    logic [6:0] level [ENCODER_COUNT];
    logic [1:0] aim_phase [ENCODER_COUNT];
    logic       aim_button [ENCODER_COUNT];

    out_item_t  pending_events [$];
    out_item_t  head_event;
    int         mismatch_count;
    int         cycle_count;
    logic       steady;

    quadrature_encoder_to_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc_item  (enc_item),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_item  (evt_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        evt_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            evt_ready <= steady || ($urandom_range(0, 99) >= 31);
        end
    end

    function automatic int ring_pos(input logic [1:0] p);
        case (p)
            2'b00:   return 0;
            2'b01:   return 1;
            2'b11:   return 2;
            default: return 3;
        endcase
    endfunction

    function automatic int clamp_value(input int v);
        if (v < int'(VAL_MIN))
            return int'(VAL_MIN);
        if (v > int'(VAL_MAX))
            return int'(VAL_MAX);
        return v;
    endfunction

    function automatic out_item_t make_event(input logic kind, input int e, input int value);
        out_item_t r;
        r.event_kind = kind;
        r.event_encoder = e[4:0];
        r.event_value = value[6:0];
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic in_item_t make_sample(input int e, input logic [1:0] p, input logic b);
        in_item_t s;
        s.encoder_index = e[4:0];
        s.quad_phase = p;
        s.button_raw = b;
        return s;
    endfunction

    function automatic logic [31:0] cfg_value(input reg_idx_t idx);
        case (idx)
            REG_DETENT_ONLY:       return {31'd0, model_cfg.detent_only};
            REG_BUTTON_MULTIPLIES: return {31'd0, model_cfg.button_multiplies};
            REG_ABSOLUTE_MODE:     return {31'd0, model_cfg.absolute_mode};
            default:               return {25'd0, model_cfg.step_multiplier};
        endcase
    endfunction

    task automatic predict_events(input in_item_t s);
        int        e;
        int        i;
        int        n;
        int        mv;
        int        v;
        logic      same;
        out_item_t found [2];
        e = int'(s.encoder_index);
        n = 0;
        for (i = HISTORY_DEPTH - 1; i > 0; i--)
        begin
            phase_log[e][i] = phase_log[e][i-1];
            button_log[e][i] = button_log[e][i-1];
        end
        phase_log[e][0] = s.quad_phase;
        button_log[e][0] = s.button_raw;

        same = 1'b1;
        for (i = 1; i < HISTORY_DEPTH; i++)
            if (phase_log[e][i] != s.quad_phase)
                same = 1'b0;
        if (same && s.quad_phase != settled_phase[e])
        begin
            if (!model_cfg.detent_only || s.quad_phase == PHASE_ZERO
                || s.quad_phase == PHASE_ALL_ONES)
            begin
                case ((ring_pos(s.quad_phase) - ring_pos(settled_phase[e]) + 4) % 4)
                    1:       mv = 1;
                    3:       mv = -1;
                    default: mv = 0;
                endcase
                if (mv != 0)
                begin
                    if (model_cfg.button_multiplies && !settled_button[e])
                        mv = mv * int'(model_cfg.step_multiplier);
                    if (model_cfg.absolute_mode)
                    begin
                        v = clamp_value(int'(level[e]) + mv);
                        if (v != int'(level[e]))
                        begin
                            level[e] = v[6:0];
                            found[n] = make_event(KIND_ENCODER, e, v);
                            n++;
                        end
                    end
                    else
                    begin
                        found[n] = make_event(KIND_ENCODER, e, clamp_value(int'(VAL_MID) + mv));
                        n++;
                    end
                end
            end
            settled_phase[e] = s.quad_phase;
        end

        same = 1'b1;
        for (i = 1; i < HISTORY_DEPTH; i++)
            if (button_log[e][i] != s.button_raw)
                same = 1'b0;
        if (same && s.button_raw != settled_button[e])
        begin
            settled_button[e] = s.button_raw;
            if (!model_cfg.button_multiplies)
            begin
                found[n] = make_event(KIND_BUTTON, e,
                                      int'(s.button_raw ? VAL_MIN : VAL_MAX));
                n++;
            end
        end

        if (n > 0)
            found[n-1].last_of_run = 1'b1;
        for (i = 0; i < n; i++)
            pending_events.push_back(found[i]);
    endtask

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && evt_valid && evt_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t ns: expected no item, actual kind %0d encoder %0d value %0d last %0d",
                         $time, evt_item.event_kind, evt_item.event_encoder,
                         evt_item.event_value, evt_item.last_of_run);
                mismatch_count++;
            end
            else
            begin
                head_event = pending_events.pop_front();
                flag_field("event_kind", int'(head_event.event_kind),
                           int'(evt_item.event_kind));
                flag_field("event_encoder", int'(head_event.event_encoder),
                           int'(evt_item.event_encoder));
                flag_field("event_value", int'(head_event.event_value),
                           int'(evt_item.event_value));
                flag_field("last_of_run", int'(head_event.last_of_run),
                           int'(evt_item.last_of_run));
            end
        end
    end

    task automatic send_item(input in_item_t it);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 31)
            begin
                @(negedge clk);
                enc_valid <= 1'b0;
                @(posedge clk);
            end
        end
        @(negedge clk);
        enc_valid <= 1'b1;
        enc_item <= it;
        do
            @(posedge clk);
        while (!enc_ready);
        predict_events(it);
    endtask

    task automatic settle(input int e, input logic [1:0] p, input logic b);
        repeat (HISTORY_DEPTH)
            send_item(make_sample(e, p, b));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        enc_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [6:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {25'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DETENT_ONLY:       model_cfg.detent_only = value[0];
            REG_BUTTON_MULTIPLIES: model_cfg.button_multiplies = value[0];
            REG_ABSOLUTE_MODE:     model_cfg.absolute_mode = value[0];
            default:               model_cfg.step_multiplier = value;
        endcase
    endtask

    task automatic check_reg(input reg_idx_t idx);
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== cfg_value(idx))
        begin
            $display("%0t ns: register %s expected %0d actual %0d",
                     $time, idx.name(), cfg_value(idx), got);
            mismatch_count++;
        end
    endtask

    task automatic check_all_regs();
        check_reg(REG_DETENT_ONLY);
        check_reg(REG_BUTTON_MULTIPLIES);
        check_reg(REG_ABSOLUTE_MODE);
        check_reg(REG_STEP_MULTIPLIER);
    endtask

    task automatic configure(input logic detent, input logic scale_by_button,
                             input logic absm, input logic [6:0] factor);
        wait_drained();
        write_reg(REG_DETENT_ONLY, {6'd0, detent});
        write_reg(REG_BUTTON_MULTIPLIES, {6'd0, scale_by_button});
        write_reg(REG_ABSOLUTE_MODE, {6'd0, absm});
        write_reg(REG_STEP_MULTIPLIER, factor);
    endtask

    task automatic random_traffic(input int n_items);
        int  sent;
        int  e;
        int  kind;
        int  reps;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 5))
                0:       e = 0;
                1:       e = ENCODER_COUNT - 1;
                2:       e = 7;
                3:       e = 18;
                default: e = $urandom_range(0, ENCODER_COUNT - 1);
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                send_item(in_item_t'(8'($urandom_range(0, 255))));
                sent++;
            end
            else
            begin
                if (kind < 80)
                    aim_phase[e] = GRAY_RING[(ring_pos(aim_phase[e])
                                              + ($urandom_range(0, 1) ? 1 : 3)) % 4];
                else
                    aim_phase[e] = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    aim_button[e] = ~aim_button[e];
                if ($urandom_range(0, 5) == 0)
                    reps = $urandom_range(1, HISTORY_DEPTH - 1);
                else
                    reps = HISTORY_DEPTH;
                repeat (reps)
                    send_item(make_sample(e, aim_phase[e], aim_button[e]));
                sent += reps;
            end
        end
    endtask

    task automatic test_register_access();
        check_all_regs();
        configure(1'b0, 1'b0, 1'b1, 7'd127);
        check_all_regs();
    endtask

    task automatic test_relative_steps();
        configure(1'b0, 1'b1, 1'b0, 7'd127);
        settle(0, 2'b10, 1'b1);
        settle(0, 2'b00, 1'b0);
        settle(0, 2'b01, 1'b0);
        settle(0, 2'b00, 1'b0);
        settle(ENCODER_COUNT - 1, 2'b00, 1'b1);
        configure(1'b0, 1'b1, 1'b0, 7'd0);
        settle(0, 2'b01, 1'b0);
    endtask

    task automatic test_absolute_mode();
        configure(1'b1, 1'b1, 1'b1, 7'd127);
        settle(ENCODER_COUNT - 1, 2'b10, 1'b0);
        settle(ENCODER_COUNT - 1, 2'b00, 1'b0);
    endtask

    task automatic test_button_events();
        configure(1'b0, 1'b0, 1'b0, 7'd8);
        settle(5, 2'b01, 1'b0);
        settle(5, 2'b01, 1'b1);
    endtask

    task automatic test_random_modes();
        configure(1'b1, 1'b1, 1'b0, 7'd8);
        random_traffic(200);
        configure(1'b0, 1'b1, 1'b1, 7'd127);
        random_traffic(200);
        configure(1'b1, 1'b0, 1'b0, 7'd0);
        random_traffic(100);
        wait_drained();
        random_traffic(100);
        configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
        random_traffic(200);
    endtask

    task automatic test_random_steady();
        steady = 1'b1;
        configure(1'b0, 1'b0, 1'b1, 7'($urandom_range(1, 126)));
        random_traffic(200);
        wait_drained();
        steady = 1'b0;
    endtask

    initial
    begin
        int e;
        int i;
        rst_n <= 1'b0;
        enc_valid <= 1'b0;
        enc_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        steady = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        model_cfg.detent_only = 1'b1;
        model_cfg.button_multiplies = 1'b1;
        model_cfg.absolute_mode = 1'b0;
        model_cfg.step_multiplier = 7'd8;
        for (e = 0; e < ENCODER_COUNT; e++)
        begin
            for (i = 0; i < HISTORY_DEPTH; i++)
            begin
                phase_log[e][i] = PHASE_ALL_ONES;
                button_log[e][i] = 1'b1;
            end
            settled_phase[e] = PHASE_ALL_ONES;
            settled_button[e] = 1'b1;
            level[e] = VAL_MIN;
            aim_phase[e] = PHASE_ALL_ONES;
            aim_button[e] = 1'b1;
        end
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_relative_steps();
        test_absolute_mode();
        test_button_events();
        test_random_modes();
        test_random_steady();

        wait_drained();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
